@@ rtl/controlled_gate_state_vector_macros.svh @@
// Assertion macros for the state vector engine
`ifndef CONTROLLED_GATE_STATE_VECTOR_MACROS_SVH
`define CONTROLLED_GATE_STATE_VECTOR_MACROS_SVH
`define CGSV_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define CGSV_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ rtl/cgsv_pkg.sv @@
// Package: types, constants and arithmetic helpers of the state vector engine
`default_nettype none
package cgsv_pkg;
    localparam int MAX_QUBITS = 10;
    localparam int DEPTH = 1 << MAX_QUBITS;
    localparam int AW = MAX_QUBITS;
    localparam int QW = 4;
    localparam int AMPW = 32;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_GATE = 2'd2;
    localparam logic [1:0] CMD_SWAP = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_RD0, S_RD1, S_MUL, S_SUM, S_WR0, S_WR1, S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [AW-1:0]   index;
        logic [AMPW-1:0] amp;
        logic [QW-1:0]   target_qubit;
        logic [QW-1:0]   second_qubit;
        logic [AW-1:0]   include_mask;
        logic [AW-1:0]   ctrl_value;
        logic [AMPW-1:0] m00;
        logic [AMPW-1:0] m01;
        logic [AMPW-1:0] m10;
        logic [AMPW-1:0] m11;
    } t_cmd;

    typedef struct packed {
        logic [AMPW-1:0] read_amp;
        logic            status;
    } t_rsp;

    function automatic logic [15:0] round_sat(input logic signed [34:0] acc);
        logic signed [34:0] v;
        logic signed [20:0] q;
        v = acc + 35'sd8192;
        q = v[34:14];
        if (q > 21'sd32767) round_sat = 16'h7fff;
        else if (q < -21'sd32768) round_sat = 16'h8000;
        else round_sat = q[15:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/cgsv_if.sv @@
// Valid/ready channel interface carrying a payload
`default_nettype none
interface cgsv_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/cgsv_ram.sv @@
// Generic single-port RAM with registered read
`default_nettype none
module cgsv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ rtl/cgsv_cmac.sv @@
// Shared complex multiply-accumulate unit: one 16x16 product per cycle
`default_nettype none
module cgsv_cmac (
    input  wire         i_clk,
    input  wire         i_start,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_x,
    input  wire  [31:0] i_b,
    input  wire  [31:0] i_y,
    output logic        o_done,
    output logic [31:0] o_result
);
    logic [2:0]          r_step;
    logic                r_busy;
    logic signed [34:0]  r_re, r_im;
    logic signed [15:0]  w_p, w_q;
    logic signed [31:0]  w_prod;
    logic signed [31:0]  r_prod;
    logic [2:0]          r_pstep;
    logic                r_pvalid;

    always_comb begin
        case (r_step)
            3'd0: begin w_p = i_a[31:16]; w_q = i_x[31:16]; end
            3'd1: begin w_p = i_a[15:0];  w_q = i_x[15:0];  end
            3'd2: begin w_p = i_b[31:16]; w_q = i_y[31:16]; end
            3'd3: begin w_p = i_b[15:0];  w_q = i_y[15:0];  end
            3'd4: begin w_p = i_a[31:16]; w_q = i_x[15:0];  end
            3'd5: begin w_p = i_a[15:0];  w_q = i_x[31:16]; end
            3'd6: begin w_p = i_b[31:16]; w_q = i_y[15:0];  end
            default: begin w_p = i_b[15:0]; w_q = i_y[31:16]; end
        endcase
        w_prod = w_p * w_q;
    end

    always_ff @(posedge i_clk) begin
        o_done <= !i_start && r_pvalid && (r_pstep == 3'd7);
        if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 3'd0;
            r_re <= '0;
            r_im <= '0;
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= r_busy;
            r_prod   <= w_prod;
            r_pstep  <= r_step;
            if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) r_busy <= 1'b0;
            end
            if (r_pvalid) begin
                case (r_pstep)
                    3'd1, 3'd3: r_re <= r_re - 35'(r_prod);
                    3'd0, 3'd2: r_re <= r_re + 35'(r_prod);
                    default:    r_im <= r_im + 35'(r_prod);
                endcase
            end
        end
    end

    assign o_result = {cgsv_pkg::round_sat(r_re), cgsv_pkg::round_sat(r_im)};
endmodule
`default_nettype wire

@@ rtl/controlled_gate_state_vector.sv @@
// Top level: state vector store with pair-walking sequencer and shared complex MAC
// Gate: walks the 2^n indices and, per matching pair, runs two 8-product passes of the
// one 16x16 multiplier; all reads and writes share the one RAM port. Swap: walks the same
// indices and exchanges each swapped pair. A new item is taken only after the result
// leaves. Reset clears control state, sets active_qubits to 10, not the store.
`default_nettype none
`include "controlled_gate_state_vector_macros.svh"
module controlled_gate_state_vector (
    input  wire i_clk,
    input  wire i_rst_n,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [3:0]  i_cfg_data,
    cgsv_if.sink   in_ch,
    cgsv_if.source out_ch
);
    localparam int AW = cgsv_pkg::AW;

    cgsv_pkg::t_state r_state, n_state;
    cgsv_pkg::t_cmd   r_cmd;
    logic [3:0]       r_active;
    logic [AW:0]      r_k;
    logic [AW-1:0]    r_k1, r_k2;
    logic [31:0]      r_s1, r_s2, r_new1;
    logic             r_half;
    logic             r_status;
    logic [31:0]      r_rd;
    logic             r_ovalid;

    logic [3:0]       w_n;
    logic [AW:0]      w_size;
    logic [AW-1:0]    w_mask, w_hb, w_qb, w_kk, w_pair;
    logic             w_match, w_err;
    logic             w_we;
    logic [AW-1:0]    w_addr;
    logic [31:0]      w_wdata, w_rdata;
    logic             w_mstart, w_mdone;
    logic [31:0]      w_a, w_b, w_mres;

    assign o_cfg_ready = (r_state == cgsv_pkg::S_IDLE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_active <= 4'd10;
        else if (i_cfg_valid && o_cfg_ready) r_active <= i_cfg_data;
    end

    always_comb begin
        w_n = r_active;
        if (w_n < 4'd1) w_n = 4'd1;
        if (w_n > 4'(cgsv_pkg::MAX_QUBITS)) w_n = 4'(cgsv_pkg::MAX_QUBITS);
        w_size = (AW+1)'(1) << w_n;
        w_mask = AW'(w_size - (AW+1)'(1));
        w_hb = AW'(1) << r_cmd.target_qubit;
        w_qb = AW'(1) << r_cmd.second_qubit;
        w_kk = r_k[AW-1:0];
        w_match = ((w_kk & r_cmd.include_mask) == (r_cmd.ctrl_value & r_cmd.include_mask));
        if (r_cmd.cmd == cgsv_pkg::CMD_GATE) begin
            w_match = w_match && ((w_kk & w_hb) == '0);
            w_pair = w_kk | w_hb;
            w_err = (r_cmd.target_qubit >= w_n);
        end else begin
            w_match = w_match && ((w_kk & w_hb) != '0) && ((w_kk & w_qb) == '0)
                && (r_cmd.target_qubit != r_cmd.second_qubit);
            w_pair = (w_kk & ~w_hb) | w_qb;
            w_err = (r_cmd.target_qubit >= w_n) || (r_cmd.second_qubit >= w_n);
        end
    end

    cgsv_ram #(.WIDTH(32), .DEPTH(cgsv_pkg::DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    assign w_a = r_half ? r_cmd.m10 : r_cmd.m00;
    assign w_b = r_half ? r_cmd.m11 : r_cmd.m01;
    cgsv_cmac u_cmac (
        .i_clk(i_clk), .i_start(w_mstart), .i_a(w_a), .i_x(r_s1), .i_b(w_b), .i_y(r_s2),
        .o_done(w_mdone), .o_result(w_mres)
    );

    assign in_ch.ready = (r_state == cgsv_pkg::S_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data = '{read_amp: r_rd, status: r_status};

    always_comb begin
        n_state = r_state;
        w_we = 1'b0;
        w_addr = r_k1;
        w_wdata = r_new1;
        w_mstart = 1'b0;
        case (r_state)
            cgsv_pkg::S_IDLE: begin
                w_addr = in_ch.data.index & w_mask;
                w_wdata = in_ch.data.amp;
                if (in_ch.valid && in_ch.ready) begin
                    if (in_ch.data.cmd == cgsv_pkg::CMD_LOAD) begin
                        w_we = 1'b1;
                        n_state = cgsv_pkg::S_DONE;
                    end else if (in_ch.data.cmd == cgsv_pkg::CMD_READ) begin
                        n_state = cgsv_pkg::S_RD1;
                    end else begin
                        n_state = cgsv_pkg::S_RD0;
                    end
                end
            end
            cgsv_pkg::S_RD0: begin
                w_addr = w_kk;
                if (w_err || r_k == w_size) n_state = cgsv_pkg::S_DONE;
                else if (w_match) n_state = cgsv_pkg::S_RD1;
            end
            cgsv_pkg::S_RD1: begin
                w_addr = r_k2;
                if (r_cmd.cmd == cgsv_pkg::CMD_READ) n_state = cgsv_pkg::S_DONE;
                else n_state = cgsv_pkg::S_MUL;
            end
            cgsv_pkg::S_MUL: begin
                w_addr = r_k2;
                if (r_cmd.cmd == cgsv_pkg::CMD_SWAP) n_state = cgsv_pkg::S_WR0;
                else begin
                    w_mstart = 1'b1;
                    n_state = cgsv_pkg::S_SUM;
                end
            end
            cgsv_pkg::S_SUM: begin
                if (w_mdone) begin
                    if (r_half) n_state = cgsv_pkg::S_WR0;
                    else w_mstart = 1'b1;
                end
            end
            cgsv_pkg::S_WR0: begin
                w_we = 1'b1;
                w_addr = r_k1;
                w_wdata = (r_cmd.cmd == cgsv_pkg::CMD_SWAP) ? r_s2 : r_new1;
                n_state = cgsv_pkg::S_WR1;
            end
            cgsv_pkg::S_WR1: begin
                w_we = 1'b1;
                w_addr = r_k2;
                w_wdata = (r_cmd.cmd == cgsv_pkg::CMD_SWAP) ? r_s1 : w_mres;
                n_state = cgsv_pkg::S_RD0;
            end
            cgsv_pkg::S_DONE: begin
                n_state = cgsv_pkg::S_IDLE;
            end
            default: n_state = cgsv_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= cgsv_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (r_state == cgsv_pkg::S_DONE) r_ovalid <= 1'b1;
        end
        case (r_state)
            cgsv_pkg::S_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    r_cmd <= in_ch.data;
                    r_k <= '0;
                    r_status <= 1'b0;
                    r_rd <= '0;
                    r_k2 <= in_ch.data.index & w_mask;
                end
            end
            cgsv_pkg::S_RD0: begin
                if (w_err) r_status <= 1'b1;
                r_k1 <= w_kk;
                r_k2 <= w_pair;
                r_half <= 1'b0;
                r_k <= r_k + (AW+1)'(1);
            end
            cgsv_pkg::S_RD1: begin
                r_s1 <= w_rdata;
                if (r_cmd.cmd == cgsv_pkg::CMD_READ) r_rd <= w_rdata;
            end
            cgsv_pkg::S_MUL: begin
                r_s2 <= w_rdata;
            end
            cgsv_pkg::S_SUM: begin
                if (w_mdone) begin
                    if (!r_half) r_new1 <= w_mres;
                    r_half <= !r_half;
                end
            end
            default: ;
        endcase
    end

    `CGSV_ASSERT_IMPL(a_no_out_while_busy, i_clk, i_rst_n,
        r_ovalid, r_state == cgsv_pkg::S_IDLE)
    `CGSV_ASSERT_NEXT(a_done_gives_out, i_clk, i_rst_n,
        r_state == cgsv_pkg::S_DONE, r_ovalid)
    `CGSV_ASSERT_IMPL(a_write_only_when_owned, i_clk, i_rst_n,
        w_we, r_state != cgsv_pkg::S_RD0 && r_state != cgsv_pkg::S_SUM)
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench of the controlled-gate state vector engine with a predicting scoreboard
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int CYCLE_LIMIT = 6000000;

    class amp_scoreboard;
        logic [cgsv_pkg::AMPW-1:0] amps[cgsv_pkg::DEPTH];
        bit                        written[cgsv_pkg::DEPTH];
        logic [3:0]                qubit_reg;
        cgsv_pkg::t_rsp            expected_q[$];
        int                        mismatches;

        function new();
            qubit_reg = 4'd10;
            mismatches = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function int qubits();
            if (qubit_reg < 1) return 1;
            if (qubit_reg > cgsv_pkg::MAX_QUBITS) return cgsv_pkg::MAX_QUBITS;
            return int'(qubit_reg);
        endfunction

        function logic [15:0] round_clip(longint acc);
            longint q;
            q = (acc + 64'sd8192) >>> 14;
            if (q > 32767) return 16'h7fff;
            if (q < -32768) return 16'h8000;
            return q[15:0];
        endfunction

        function longint part(logic [15:0] v);
            return longint'($signed(v));
        endfunction

        // a*x + b*y on packed complex values
        function logic [31:0] cmul_add(logic [31:0] a, logic [31:0] x,
                                        logic [31:0] b, logic [31:0] y);
            longint re, im;
            re = part(a[31:16]) * part(x[31:16]) - part(a[15:0]) * part(x[15:0])
               + part(b[31:16]) * part(y[31:16]) - part(b[15:0]) * part(y[15:0]);
            im = part(a[31:16]) * part(x[15:0]) + part(a[15:0]) * part(x[31:16])
               + part(b[31:16]) * part(y[15:0]) + part(b[15:0]) * part(y[31:16]);
            return {round_clip(re), round_clip(im)};
        endfunction

        function void note_item(cgsv_pkg::t_cmd c);
            int n, size, k, k2, half, ma, mb;
            logic [cgsv_pkg::AW-1:0] des;
            logic [31:0] s1, s2;
            cgsv_pkg::t_rsp r;
            n = qubits();
            size = 1 << n;
            des = c.ctrl_value & c.include_mask;
            r.read_amp = '0;
            r.status = 1'b0;
            case (c.cmd)
                cgsv_pkg::CMD_LOAD: begin
                    amps[c.index & (size - 1)] = c.amp;
                    written[c.index & (size - 1)] = 1'b1;
                end
                cgsv_pkg::CMD_READ: r.read_amp = amps[c.index & (size - 1)];
                cgsv_pkg::CMD_GATE: begin
                    if (c.target_qubit >= n) begin
                        r.status = 1'b1;
                    end else begin
                        half = 1 << c.target_qubit;
                        for (k = 0; k < size; k++) begin
                            if ((k & half) != 0 || (k & c.include_mask) != des) continue;
                            k2 = k | half;
                            s1 = amps[k];
                            s2 = amps[k2];
                            amps[k] = cmul_add(c.m00, s1, c.m01, s2);
                            amps[k2] = cmul_add(c.m10, s1, c.m11, s2);
                        end
                    end
                end
                default: begin
                    if (c.target_qubit >= n || c.second_qubit >= n) begin
                        r.status = 1'b1;
                    end else if (c.target_qubit != c.second_qubit) begin
                        ma = 1 << c.target_qubit;
                        mb = 1 << c.second_qubit;
                        for (k = 0; k < size; k++) begin
                            if ((k & c.include_mask) != des) continue;
                            if ((k & ma) == 0 || (k & mb) != 0) continue;
                            k2 = (k & ~ma) | mb;
                            s1 = amps[k];
                            amps[k] = amps[k2];
                            amps[k2] = s1;
                        end
                    end
                end
            endcase
            expected_q.insert(expected_q.size(), r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
            mismatches++;
        endtask

        task check_result(cgsv_pkg::t_rsp got);
            cgsv_pkg::t_rsp want;
            if (expected_q.size() == 0) begin
                report("unexpected result", got.read_amp, '0);
            end else begin
                want = expected_q.pop_front();
                if (got.read_amp !== want.read_amp) report("read_amp", got.read_amp, want.read_amp);
                if (got.status !== want.status)
                    report("status", 32'(got.status), 32'(want.status));
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data;
    int         cycles;
    amp_scoreboard sb;

    cgsv_if #(.T(cgsv_pkg::t_cmd)) cmd_if ();
    cgsv_if #(.T(cgsv_pkg::t_rsp)) rsp_if ();

    controlled_gate_state_vector i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .in_ch      (cmd_if.sink),
        .out_ch     (rsp_if.source)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** controlled_gate_state_vector: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int len;
        rsp_if.ready = 1'b0;
        forever begin
            if ($urandom_range(0, 99) < 65) begin
                len = $urandom_range(1, 30);
                rsp_if.ready <= 1'b1;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
                rsp_if.ready <= 1'b0;
            end
            repeat (len) @(negedge i_clk);
        end
    end

    task send_item(cgsv_pkg::t_cmd c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.data <= c;
        cmd_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_item(c);
        @(negedge i_clk);
    endtask

    task drain();
        cmd_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task write_qubits(logic [3:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.qubit_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function cgsv_pkg::t_cmd blank_item(logic [1:0] op);
        cgsv_pkg::t_cmd c;
        c = '0;
        c.cmd = op;
        return c;
    endfunction

    function logic [31:0] pick_entry();
        case ($urandom_range(0, 9))
            0: return 32'h4000_0000;
            1: return 32'h2d41_0000;
            2: return 32'hc000_0000;
            3: return 32'h0000_4000;
            4: return 32'h7fff_7fff;
            5: return 32'h8000_8000;
            6: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // on a full-size vector only written entries are read and gates and swaps stay out of range
    function cgsv_pkg::t_cmd random_item(int heavy);
        cgsv_pkg::t_cmd c;
        int n, r, t;
        logic [cgsv_pkg::AW-1:0] lowmask;
        n = sb.qubits();
        lowmask = cgsv_pkg::AW'((1 << n) - 1);
        c = '0;
        r = $urandom_range(0, 99);
        if (heavy) c.cmd = (r < 45) ? cgsv_pkg::CMD_LOAD : (r < 92) ? cgsv_pkg::CMD_READ
                         : (r < 96) ? cgsv_pkg::CMD_GATE : cgsv_pkg::CMD_SWAP;
        else c.cmd = (r < 30) ? cgsv_pkg::CMD_LOAD : (r < 60) ? cgsv_pkg::CMD_READ
                   : (r < 85) ? cgsv_pkg::CMD_GATE : cgsv_pkg::CMD_SWAP;
        c.index = cgsv_pkg::AW'($urandom);
        if (heavy && c.cmd == cgsv_pkg::CMD_READ) begin
            for (t = 0; t < 16 && !sb.written[c.index]; t++) c.index = cgsv_pkg::AW'($urandom);
            if (!sb.written[c.index]) c.index = '0;
        end
        c.amp = ($urandom_range(0, 3) == 0) ? pick_entry() : $urandom;
        c.target_qubit = ($urandom_range(0, 7) == 0) ? cgsv_pkg::QW'($urandom_range(0, 15))
                                                      : cgsv_pkg::QW'($urandom_range(0, n - 1));
        c.second_qubit = ($urandom_range(0, 7) == 0) ? cgsv_pkg::QW'($urandom_range(0, 15))
                                                      : cgsv_pkg::QW'($urandom_range(0, n - 1));
        if (heavy && (c.cmd == cgsv_pkg::CMD_GATE || c.cmd == cgsv_pkg::CMD_SWAP))
            c.target_qubit = cgsv_pkg::QW'($urandom_range(n, 15));
        r = $urandom_range(0, 9);
        c.include_mask = (r < 4) ? '0 : (r < 9) ? (cgsv_pkg::AW'($urandom) & lowmask)
                                                : cgsv_pkg::AW'($urandom);
        c.ctrl_value = ($urandom_range(0, 3) == 0) ? cgsv_pkg::AW'($urandom)
                                                    : (cgsv_pkg::AW'($urandom) & c.include_mask);
        c.m00 = pick_entry();
        c.m01 = pick_entry();
        c.m10 = pick_entry();
        c.m11 = pick_entry();
        return c;
    endfunction

    task fill_vector();
        cgsv_pkg::t_cmd c;
        int i;
        for (i = 0; i < (1 << sb.qubits()); i++) begin
            if (!sb.written[i]) begin
                c = blank_item(cgsv_pkg::CMD_LOAD);
                c.index = cgsv_pkg::AW'(i);
                c.amp = $urandom;
                send_item(c);
            end
        end
    endtask

    task directed_items();
        cgsv_pkg::t_cmd c;
        int i;
        logic [31:0] vals[8];
        vals = '{32'h0, 32'hffff_ffff, 32'h8000_8000, 32'h7fff_7fff,
                 32'h4000_c000, 32'h0001_ffff, 32'h2d41_2d41, 32'h8000_7fff};
        for (i = 0; i < 8; i++) begin
            c = blank_item(cgsv_pkg::CMD_LOAD);
            c.index = cgsv_pkg::AW'(i);
            c.amp = vals[i];
            send_item(c);
        end
        c = blank_item(cgsv_pkg::CMD_READ);
        c.index = 10'h3ff;
        send_item(c);
        c = blank_item(cgsv_pkg::CMD_GATE);
        c.target_qubit = 4'd1;
        c.m00 = 32'h4000_0000;
        c.m11 = 32'h4000_0000;
        send_item(c);
        c.m00 = 32'h7fff_7fff;
        c.m01 = 32'h7fff_7fff;
        c.m10 = 32'h8000_8000;
        c.m11 = 32'h8000_7fff;
        c.target_qubit = 4'd0;
        send_item(c);
        c.target_qubit = 4'd2;
        c.include_mask = 10'h3;
        c.ctrl_value = 10'h2;
        send_item(c);
        c.include_mask = 10'h200;
        c.ctrl_value = 10'h200;
        send_item(c);
        c.target_qubit = 4'd3;
        send_item(c);
        c.target_qubit = 4'd15;
        send_item(c);
        c = blank_item(cgsv_pkg::CMD_SWAP);
        c.target_qubit = 4'd2;
        c.second_qubit = 4'd0;
        send_item(c);
        c.second_qubit = 4'd2;
        send_item(c);
        c.target_qubit = 4'd0;
        c.second_qubit = 4'd1;
        c.include_mask = 10'h3ff;
        c.ctrl_value = 10'h3fd;
        send_item(c);
        c.second_qubit = 4'd3;
        send_item(c);
        c.target_qubit = 4'd15;
        c.second_qubit = 4'd15;
        send_item(c);
        for (i = 0; i < 8; i++) begin
            c = blank_item(cgsv_pkg::CMD_READ);
            c.index = cgsv_pkg::AW'(i) | 10'h3f8;
            send_item(c);
        end
    endtask

    initial begin
        int p, j;
        logic [3:0] settings[10];
        int counts[10];
        settings = '{4'd1, 4'd2, 4'd4, 4'd5, 4'd0, 4'd3, 4'd6, 4'd2, 4'd10, 4'd15};
        counts = '{130, 140, 180, 140, 60, 140, 100, 100, 60, 40};
        sb = new();
        cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 4'd0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_qubits(4'd3);
        directed_items();
        drain();
        for (p = 0; p < 10; p++) begin
            write_qubits(settings[p]);
            if (sb.qubits() < cgsv_pkg::MAX_QUBITS) fill_vector();
            for (j = 0; j < counts[p]; j++)
                send_item(random_item(int'(sb.qubits() >= cgsv_pkg::MAX_QUBITS)));
            drain();
        end
        if (sb.mismatches == 0) begin
            $display("** controlled_gate_state_vector: PASSED **");
        end else begin
            $display("** controlled_gate_state_vector: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
